// ----- sv/form_urlencoded_decoder_assert.svh -----
// ---------------------------------------------------------------------------
// form_urlencoded_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef FORM_URLENCODED_DECODER_ASSERT_SVH
`define FORM_URLENCODED_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FUD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define FUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/fud_pkg.sv -----
// ---------------------------------------------------------------------------
// fud_pkg
// Types, character codes and helpers for the form-urlencoded decoder.
// ---------------------------------------------------------------------------
package fud_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_PAIR = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // Escape tracking phases
    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_HEX1   = 2'd1,
        PH_HEX2   = 2'd2,
        PH_ERROR  = 2'd3
    } phase_t;

    // Character codes
    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_AMP     = 8'h26;
    localparam logic [7:0] CHR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_DEL     = 8'h7F;
    localparam logic [7:0] CHR_HIGH    = 8'h80;

    // Decoder state
    typedef struct packed {
        logic       value_mode;
        phase_t     phase;
        logic [3:0] high_nibble;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{value_mode: 1'b0, phase: PH_NORMAL,
                                           high_nibble: 4'd0};

    // One result item plus its strobe
    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic       in_value_part;
        kind_t      kind;
    } dec_result_t;

    // Hex digit check; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

// ----- sv/fud_in_if.sv -----
// ---------------------------------------------------------------------------
// fud_in_if
// Input channel: one raw query byte or an end-of-input mark per item.
// ---------------------------------------------------------------------------
interface fud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_end;

    modport source (output valid, output in_byte, output is_end, input ready);
    modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

// ----- sv/fud_out_if.sv -----
// ---------------------------------------------------------------------------
// fud_out_if
// Output channel: one decoded byte, pair marker or error per item.
// ---------------------------------------------------------------------------
interface fud_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       in_value_part;
    logic [1:0] kind;

    modport source (output valid, output out_byte, output in_value_part,
                    output kind, input ready);
    modport sink   (input valid, input out_byte, input in_value_part,
                    input kind, output ready);
endinterface

// ----- sv/fud_step.sv -----
// ---------------------------------------------------------------------------
// fud_step
// Single-item decode step: current state and item in, next state and result out.
// ---------------------------------------------------------------------------
module fud_step (
    input  fud_pkg::dec_state_t  state,
    input  logic [7:0]           in_byte,
    input  logic                 is_end,
    output fud_pkg::dec_state_t  state_next,
    output fud_pkg::dec_result_t result
);
    import fud_pkg::*;

    logic [4:0] hex;
    logic       non_print;

    assign hex       = hex_value(in_byte);
    assign non_print = !in_byte[7] && (in_byte < CHR_SPACE || in_byte == CHR_DEL);

    always_comb begin
        state_next = state;
        result     = '{emit: 1'b0, out_byte: 8'd0, in_value_part: 1'b0, kind: KIND_DATA};

        if (is_end) begin
            // End of input: flag open escape, close open value, then reset
            if (state.phase == PH_HEX1 || state.phase == PH_HEX2) begin
                result.emit = 1'b1;
                result.kind = KIND_ERR;
            end else if (state.phase == PH_NORMAL && state.value_mode) begin
                result.emit          = 1'b1;
                result.in_value_part = 1'b1;
                result.kind          = KIND_PAIR;
            end
            state_next = STATE_RESET;
        end else begin
            unique case (state.phase)
                PH_ERROR: begin
                    // drop bytes until end of input
                end
                PH_HEX1, PH_HEX2: begin
                    if (hex[4]) begin
                        state_next.phase = PH_ERROR;
                        result.emit      = 1'b1;
                        result.kind      = KIND_ERR;
                    end else if (state.phase == PH_HEX1) begin
                        state_next.high_nibble = hex[3:0];
                        state_next.phase       = PH_HEX2;
                    end else begin
                        state_next.phase     = PH_NORMAL;
                        result.emit          = 1'b1;
                        result.out_byte      = {state.high_nibble, hex[3:0]};
                        result.in_value_part = state.value_mode;
                    end
                end
                PH_NORMAL: begin
                    if (in_byte == CHR_AMP) begin
                        // close a value; in a name, run on into the next term
                        if (state.value_mode) begin
                            state_next.value_mode = 1'b0;
                            result.emit           = 1'b1;
                            result.in_value_part  = 1'b1;
                            result.kind           = KIND_PAIR;
                        end
                    end else if (in_byte == CHR_EQUALS) begin
                        if (state.value_mode) begin
                            result.emit          = 1'b1;
                            result.out_byte      = in_byte;
                            result.in_value_part = 1'b1;
                        end else begin
                            state_next.value_mode = 1'b1;
                        end
                    end else if (in_byte == CHR_PERCENT) begin
                        state_next.phase = PH_HEX1;
                    end else if (in_byte == CHR_PLUS) begin
                        result.emit          = 1'b1;
                        result.out_byte      = CHR_SPACE;
                        result.in_value_part = state.value_mode;
                    end else if (non_print) begin
                        state_next.phase = PH_ERROR;
                        result.emit      = 1'b1;
                        result.kind      = KIND_ERR;
                    end else begin
                        result.emit          = 1'b1;
                        result.out_byte      = in_byte;
                        result.in_value_part = state.value_mode;
                    end
                end
                default: begin
                    state_next.phase = PH_ERROR;
                end
            endcase
        end
    end

endmodule

// ----- sv/form_urlencoded_decoder.sv -----
// ---------------------------------------------------------------------------
// form_urlencoded_decoder
// Streaming decoder for form-urlencoded query strings.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                          | handshake
//  ---------+-----+----------------------------------+-------------
//  in_ch    | in  | in_byte[7:0], is_end             | valid/ready
//  out_ch   | out | out_byte[7:0], in_value_part,    | valid/ready
//           |     | kind[1:0] (data, pair, error)    |
//
//  One item per cycle sustained while out_ch does not stall; a result shows on
//  out_ch once its item has passed the input register and the result register.
//  Items that produce no result are consumed without touching out_ch.
//  rst_n low clears the decoder state and both valid flags asynchronously.
//  A stall on out_ch holds the result register; in_ch stays ready while its
//  register is empty or the result register is moving.
// ---------------------------------------------------------------------------
module form_urlencoded_decoder (
    input logic      clk,
    input logic      rst_n,
    fud_in_if.sink   in_ch,
    fud_out_if.source out_ch
);
    import fud_pkg::*;

    `include "form_urlencoded_decoder_assert.svh"

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        is_end_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t step_result;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_part_reg;
    kind_t       out_kind_reg;
    logic        advance;

    // Move the result stage when it is empty or being taken
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !in_valid_reg || advance;

    fud_step u_step (
        .state      (state_reg),
        .in_byte    (in_byte_reg),
        .is_end     (is_end_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Capture the incoming item
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ch.ready) begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ch.ready && in_ch.valid) begin
            in_byte_reg <= in_ch.in_byte;
            is_end_reg  <= in_ch.is_end;
        end
    end

    // Advance decoder state and load the result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && step_result.emit;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (advance && in_valid_reg && step_result.emit) begin
            out_byte_reg <= step_result.out_byte;
            out_part_reg <= step_result.in_value_part;
            out_kind_reg <= step_result.kind;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_byte      = out_byte_reg;
    assign out_ch.in_value_part = out_part_reg;
    assign out_ch.kind          = out_kind_reg;

    // End of input always returns the decoder to its reset state
    `FUD_ASSERT_NEXT(a_end_resets, clk, rst_n, advance && in_valid_reg && is_end_reg, state_reg == STATE_RESET)

    // Bytes in the error phase never produce a result
    `FUD_ASSERT_NEXT(a_error_silent, clk, rst_n, advance && in_valid_reg && !is_end_reg && state_reg.phase == PH_ERROR, !out_valid_reg)

    // Pair markers carry the value flag and a zero byte
    `FUD_ASSERT_NOW(a_pair_fields, clk, rst_n, out_valid_reg && out_kind_reg == KIND_PAIR, out_part_reg && out_byte_reg == 8'd0)

    // Error results carry zero fields
    `FUD_ASSERT_NOW(a_err_fields, clk, rst_n, out_valid_reg && out_kind_reg == KIND_ERR, !out_part_reg && out_byte_reg == 8'd0)

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the form-urlencoded decoder against a cycle-free predictor. A short
// table of directed items covers escapes, pair markers, errors and each kind
// of end-of-input. Random query strings follow, most of them well formed with
// random content and some with noise. Both channels idle at random in several
// phases. Every result is compared field by field with the oldest expected
// result.
// ---------------------------------------------------------------------------
module testbench;
    import fud_pkg::*;

    localparam int          RANDOM_ITEMS = 1400;
    localparam int          DRAIN_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          REPORT_MAX   = 10;

    // One decoded result as seen on out_ch
    typedef struct packed {
        logic [7:0] data;
        logic       value_part;
        kind_t      kind;
    } decoded_t;

    // One row of directed stimulus; pinned rows carry a typed-in expectation
    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        logic       pinned;
        logic       has_result;
        decoded_t   res;
    } query_row_t;

    logic clk = 1'b0;
    logic rst_n;

    fud_in_if  in_if ();
    fud_out_if out_if ();

    form_urlencoded_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    dec_state_t  decoder_state;
    decoded_t    expected_q [$];
    query_row_t  directed [$];
    int          idle_pct;
    int          stall_pct;
    int          live_count;
    int          mismatch_count;
    int unsigned cycle_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        decoded_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: unexpected result byte=%h part=%b kind=%0d", $time,
                             out_if.out_byte, out_if.in_value_part, out_if.kind);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_if.out_byte !== want.data || out_if.in_value_part !== want.value_part
                    || out_if.kind !== want.kind)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"%0t: mismatch expected byte=%h part=%b kind=%0d,",
                                  " got byte=%h part=%b kind=%0d"},
                                 $time, want.data, want.value_part, want.kind,
                                 out_if.out_byte, out_if.in_value_part, out_if.kind);
                end
            end
        end
    end

    // Hex digit value; bit 4 set means the byte is not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] ch);
        logic [7:0] lower;
        lower = ch | 8'h20;
        if (ch >= 8'h30 && ch <= 8'h39)
            return {1'b0, ch[3:0]};
        if (lower >= 8'h61 && lower <= 8'h66)
            return 5'(lower - 8'h61 + 8'd10);
        return 5'h10;
    endfunction

    // Advance the decoder state by one item and report its result, if any
    function automatic void predict_decode(input logic [7:0] ch, input logic is_end,
                                           output logic has, output decoded_t res);
        logic [4:0] nib;
        has = 1'b0;
        res = '{data: 8'h00, value_part: 1'b0, kind: KIND_DATA};
        nib = nibble_of(ch);
        if (is_end)
        begin
            if (decoder_state.phase == PH_HEX1 || decoder_state.phase == PH_HEX2)
            begin
                has = 1'b1;
                res.kind = KIND_ERR;
            end
            else if (decoder_state.phase == PH_NORMAL && decoder_state.value_mode)
            begin
                has = 1'b1;
                res.value_part = 1'b1;
                res.kind = KIND_PAIR;
            end
            decoder_state = STATE_RESET;
            return;
        end
        case (decoder_state.phase)
            PH_ERROR:
                has = 1'b0;
            PH_HEX1, PH_HEX2:
                if (nib[4])
                begin
                    decoder_state.phase = PH_ERROR;
                    has = 1'b1;
                    res.kind = KIND_ERR;
                end
                else if (decoder_state.phase == PH_HEX1)
                begin
                    decoder_state.high_nibble = nib[3:0];
                    decoder_state.phase = PH_HEX2;
                end
                else
                begin
                    decoder_state.phase = PH_NORMAL;
                    has = 1'b1;
                    res.data = {decoder_state.high_nibble, nib[3:0]};
                    res.value_part = decoder_state.value_mode;
                end
            default:
                if (ch == CHR_AMP)
                begin
                    // close a pair only when a value was open
                    if (decoder_state.value_mode)
                    begin
                        decoder_state.value_mode = 1'b0;
                        has = 1'b1;
                        res.value_part = 1'b1;
                        res.kind = KIND_PAIR;
                    end
                end
                else if (ch == CHR_EQUALS)
                begin
                    if (decoder_state.value_mode)
                    begin
                        has = 1'b1;
                        res.data = ch;
                        res.value_part = 1'b1;
                    end
                    else
                        decoder_state.value_mode = 1'b1;
                end
                else if (ch == CHR_PERCENT)
                    decoder_state.phase = PH_HEX1;
                else if (ch == CHR_PLUS)
                begin
                    has = 1'b1;
                    res.data = CHR_SPACE;
                    res.value_part = decoder_state.value_mode;
                end
                else if ((ch & CHR_HIGH) == 8'h00 && (ch < CHR_SPACE || ch == CHR_DEL))
                begin
                    decoder_state.phase = PH_ERROR;
                    has = 1'b1;
                    res.kind = KIND_ERR;
                end
                else
                begin
                    has = 1'b1;
                    res.data = ch;
                    res.value_part = decoder_state.value_mode;
                end
        endcase
    endfunction

    function automatic query_row_t pred_row(input logic [7:0] ch, input logic is_end);
        return '{ch: ch, is_end: is_end, pinned: 1'b0, has_result: 1'b0,
                 res: '{data: 8'h00, value_part: 1'b0, kind: KIND_DATA}};
    endfunction

    function automatic query_row_t pin_row(input logic [7:0] ch, input logic is_end,
                                           input logic has, input logic [7:0] data,
                                           input logic part, input kind_t kind);
        return '{ch: ch, is_end: is_end, pinned: 1'b1, has_result: has,
                 res: '{data: data, value_part: part, kind: kind}};
    endfunction

    // Printable character with no special meaning, or a byte with bit 7 set
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(8'h80, 8'hFF));
        do
            c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == CHR_PERCENT || c == CHR_AMP || c == CHR_EQUALS || c == CHR_PLUS);
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return 8'(8'h30 + v);
        if (v < 16)
            return 8'(8'h41 + v - 10);
        return 8'(8'h61 + v - 16);
    endfunction

    // Present one item at the falling edge and hold it until accepted
    task automatic send_item(input query_row_t row);
        logic     has;
        decoded_t res;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= row.ch;
        in_if.is_end  <= row.is_end;
        do
            @(posedge clk);
        while (!in_if.ready);
        if (decoder_state.phase != PH_ERROR)
            live_count = live_count + 1;
        predict_decode(row.ch, row.is_end, has, res);
        if (row.pinned)
        begin
            has = row.has_result;
            res = row.res;
        end
        if (has)
            expected_q.push_back(res);
        @(negedge clk);
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(pred_row(ch, 1'b0));
    endtask

    // Send a run of name or value characters, with noise when asked
    task automatic send_text(input logic in_value, input int len, input bit noisy);
        int r;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (noisy && r < 4)
                send_char(8'($urandom_range(0, 255)));
            else if (noisy && r < 7)
            begin
                send_char(CHR_PERCENT);
                send_char(8'($urandom_range(0, 255)));
            end
            else if (r < 15)
                send_char(CHR_PLUS);
            else if (r < 30)
            begin
                send_char(CHR_PERCENT);
                send_char(hex_char());
                send_char(hex_char());
            end
            else if (in_value && r < 35)
                send_char(CHR_EQUALS);
            else
                send_char(plain_char());
        end
    endtask

    // One query string: a few terms, an optional broken tail, then end
    task automatic send_query();
        int terms;
        int r;
        bit noisy;
        terms = $urandom_range(1, 4);
        noisy = ($urandom_range(0, 99) < 20);
        for (int t = 0; t < terms; t++)
        begin
            send_text(1'b0, $urandom_range(0, 5), noisy);
            if ($urandom_range(0, 9) != 0)
            begin
                send_char(CHR_EQUALS);
                send_text(1'b1, $urandom_range(0, 6), noisy);
            end
            if (t < terms - 1)
                send_char(CHR_AMP);
        end
        r = $urandom_range(0, 19);
        if (r == 0)
            send_char(CHR_PERCENT);
        else if (r == 1)
        begin
            send_char(CHR_PERCENT);
            send_char(hex_char());
        end
        else if (r == 2)
            send_char(CHR_AMP);
        send_item(pred_row(8'($urandom_range(0, 255)), 1'b1));
    endtask

    // Hold off the sender until every expected result has come
    task automatic settle();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_if.valid    = 1'b0;
        in_if.in_byte  = 8'h00;
        in_if.is_end   = 1'b0;
        out_if.ready   = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        live_count     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        decoder_state  = STATE_RESET;

        // name byte, equals, plus and a second equals inside the value
        directed.push_back(pin_row(8'h61, 1'b0, 1'b1, 8'h61, 1'b0, KIND_DATA));
        directed.push_back(pin_row(CHR_EQUALS, 1'b0, 1'b0, 8'h00, 1'b0, KIND_DATA));
        directed.push_back(pin_row(CHR_PLUS, 1'b0, 1'b1, CHR_SPACE, 1'b1, KIND_DATA));
        directed.push_back(pin_row(CHR_EQUALS, 1'b0, 1'b1, CHR_EQUALS, 1'b1, KIND_DATA));
        // escape with mixed-case digits, then a decoded zero byte
        directed.push_back(pred_row(CHR_PERCENT, 1'b0));
        directed.push_back(pred_row(8'h46, 1'b0));
        directed.push_back(pred_row(8'h66, 1'b0));
        directed.push_back(pred_row(CHR_PERCENT, 1'b0));
        directed.push_back(pred_row(8'h30, 1'b0));
        directed.push_back(pin_row(8'h30, 1'b0, 1'b1, 8'h00, 1'b1, KIND_DATA));
        // high byte passes through, ampersand closes the pair
        directed.push_back(pin_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, KIND_DATA));
        directed.push_back(pin_row(CHR_AMP, 1'b0, 1'b1, 8'h00, 1'b1, KIND_PAIR));
        // ampersand in a name, then end in a name
        directed.push_back(pred_row(8'h6E, 1'b0));
        directed.push_back(pin_row(CHR_AMP, 1'b0, 1'b0, 8'h00, 1'b0, KIND_DATA));
        directed.push_back(pin_row(8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, KIND_DATA));
        // non-printing byte, then end in the error phase
        directed.push_back(pin_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, KIND_ERR));
        directed.push_back(pin_row(8'h00, 1'b1, 1'b0, 8'h00, 1'b0, KIND_DATA));
        // bad hex digit
        directed.push_back(pred_row(CHR_PERCENT, 1'b0));
        directed.push_back(pin_row(CHR_AMP, 1'b0, 1'b1, 8'h00, 1'b0, KIND_ERR));
        directed.push_back(pin_row(8'h00, 1'b1, 1'b0, 8'h00, 1'b0, KIND_DATA));
        // end inside an escape
        directed.push_back(pred_row(CHR_PERCENT, 1'b0));
        directed.push_back(pred_row(8'h61, 1'b0));
        directed.push_back(pin_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b0, KIND_ERR));
        // end after a value
        directed.push_back(pred_row(CHR_EQUALS, 1'b0));
        directed.push_back(pin_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b1, KIND_PAIR));
        // delete byte in a name
        directed.push_back(pin_row(CHR_DEL, 1'b0, 1'b1, 8'h00, 1'b0, KIND_ERR));
        directed.push_back(pin_row(8'h00, 1'b1, 1'b0, 8'h00, 1'b0, KIND_DATA));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i]);
        settle();

        // random queries over four idling phases
        live_count = 0;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            while (live_count < (p + 1) * RANDOM_ITEMS / 4)
                send_query();
            settle();
        end

        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
